// File: src/json_token_scanner_macros.svh
// Assertion macros shared by the scanner's checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef JSON_TOKEN_SCANNER_MACROS_SVH
`define JSON_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define JTS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define JTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: src/jts_pkg.sv
// Package for the JSON token scanner: sizes, character codes, types.
// Used by the interfaces, the scanner core, the record queue and the checker.
`default_nettype none

package jts_pkg;

  // Sizing
  localparam int unsigned MAX_TOKENS = 128;
  localparam int unsigned MAX_DEPTH  = 16;
  localparam int unsigned POS_BITS   = 16;

  localparam int unsigned TOK_CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned STK_IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned POSX_W    = POS_BITS + 1;

  // Fixed record field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TOK_NUM_W = 7;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_POS_W = 16;
  localparam int unsigned SIZE_W    = 16;

  localparam logic [SIZE_W-1:0] COMMA_SAT = 16'd65534;

  // Record queue
  localparam int unsigned REC_FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W     = $clog2(REC_FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(REC_FIFO_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_BELOW_0 = 8'd47;
  localparam logic [CHAR_W-1:0] CH_ABOVE_9 = 8'd58;
  localparam logic [CHAR_W-1:0] CH_T_UP    = 8'd84;
  localparam logic [CHAR_W-1:0] CH_T_LO    = 8'd116;
  localparam logic [CHAR_W-1:0] CH_F_UP    = 8'd70;
  localparam logic [CHAR_W-1:0] CH_F_LO    = 8'd102;

  typedef enum logic [KIND_W-1:0] {
    KIND_OBJECT = 2'd0,
    KIND_ARRAY  = 2'd1,
    KIND_STRING = 2'd2,
    KIND_PRIM   = 2'd3
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_STR      = 2'd1,
    MODE_PRIM     = 2'd2,
    MODE_STR_DONE = 2'd3
  } scan_mode_e;

  // One open container on the nesting stack
  typedef struct packed {
    logic                 is_array;
    logic [TOK_NUM_W-1:0] index;
    logic [POS_BITS-1:0]  start;
    logic [SIZE_W-1:0]    commas;
  } nest_entry_t;

  // One token record
  typedef struct packed {
    logic [TOK_NUM_W-1:0] tok_number;
    tok_kind_e            tok_kind;
    logic [OUT_POS_W-1:0] start_pos;
    logic [OUT_POS_W-1:0] end_pos;
    logic [SIZE_W-1:0]    member_count;
    logic                 overflow;
    logic                 last_of_byte;
  } tok_rec_t;

  // Records produced by one byte; v1 implies v0
  typedef struct packed {
    logic     v0;
    logic     v1;
    tok_rec_t r0;
    tok_rec_t r1;
  } rec_pair_t;

  // Digit or the first letter of true/false
  function automatic logic is_prim_start(input logic [CHAR_W-1:0] c);
    return ((c > CH_BELOW_0) && (c < CH_ABOVE_9)) || (c == CH_T_UP) ||
           (c == CH_T_LO) || (c == CH_F_UP) || (c == CH_F_LO);
  endfunction

endpackage

`default_nettype wire

// File: src/jts_if.sv
// Handshake channels of the JSON token scanner: input bytes and token records.
// Depends on jts_pkg for the field widths.
`default_nettype none

interface jts_byte_if import jts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              doc_start;

  modport source (output valid, char_byte, doc_start, input ready);
  modport sink   (input valid, char_byte, doc_start, output ready);
endinterface

interface jts_tok_if import jts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TOK_NUM_W-1:0] tok_number;
  logic [KIND_W-1:0]    tok_kind;
  logic [OUT_POS_W-1:0] start_pos;
  logic [OUT_POS_W-1:0] end_pos;
  logic [SIZE_W-1:0]    member_count;
  logic                 overflow;
  logic                 last_of_byte;

  modport source (output valid, tok_number, tok_kind, start_pos, end_pos, member_count,
                  overflow, last_of_byte, input ready);
  modport sink   (input valid, tok_number, tok_kind, start_pos, end_pos, member_count,
                  overflow, last_of_byte, output ready);
endinterface

`default_nettype wire

// File: src/json_token_scanner.sv
// Top level of the JSON token scanner: scanner core followed by a record queue.
// Depends on jts_pkg, jts_if, jts_scan_core and jts_rec_fifo.
//
// The scanner takes one document byte per cycle, unless held by the record queue,
// and emits a record each time an object, array, string or primitive completes.
// A byte enters an input register and is scanned from there against the stack
// top and the scan state once the record queue has room. Its records (zero, one
// or two) land in a four-entry record queue at the end of the scan cycle, and the
// queue offers them on the output in order.
// The sustained rate is one byte per cycle; it is set by the record queue, which
// delivers one record per cycle and lets a byte be scanned only while at most two
// entries are filled, so bytes slow down only while records are produced
// faster than one per cycle or the output side stalls. doc_start on a byte
// restarts position, token count, nesting, scan mode, the done flag and the overflow
// flag before that byte is scanned.
`default_nettype none

module json_token_scanner import jts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jts_byte_if.sink  char_i,
  jts_tok_if.source tok_o
);

  rec_pair_t push;
  logic      room;

  jts_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .room_i (room),
    .push_o (push)
  );

  jts_rec_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

`default_nettype wire

// File: src/jts_rec_fifo.sv
// Small record queue that takes up to two records a cycle and drives the output channel.
// Depends on jts_pkg and jts_tok_if.
`default_nettype none

module jts_rec_fifo import jts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  rec_pair_t      push_i,
  output logic           room_o,
  jts_tok_if.source      tok_o
);

  tok_rec_t              mem_q [REC_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] head_q, head_d;
  logic [FIFO_PTR_W-1:0] tail_q, tail_d;
  logic [FIFO_PTR_W-1:0] tail_nx;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [FIFO_CNT_W-1:0] push_n;
  logic                  pop;
  tok_rec_t              head_rec;

  // Room for a full pair of records
  assign room_o = (cnt_q <= FIFO_CNT_W'(REC_FIFO_DEPTH - 2));

  assign pop     = tok_o.valid && tok_o.ready;
  assign push_n  = FIFO_CNT_W'(push_i.v0) + FIFO_CNT_W'(push_i.v1);
  assign tail_nx = tail_q + 1'b1;

  // Advance pointers and occupancy
  always_comb begin
    head_d = pop ? head_q + 1'b1 : head_q;
    tail_d = tail_q + FIFO_PTR_W'(push_n);
    cnt_d  = cnt_q + push_n - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the records in arrival order
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[tail_nx] <= push_i.r1;
    end
  end

  // Drive the head record
  assign head_rec           = mem_q[head_q];
  assign tok_o.valid        = (cnt_q != '0);
  assign tok_o.tok_number   = head_rec.tok_number;
  assign tok_o.tok_kind     = head_rec.tok_kind;
  assign tok_o.start_pos    = head_rec.start_pos;
  assign tok_o.end_pos      = head_rec.end_pos;
  assign tok_o.member_count = head_rec.member_count;
  assign tok_o.overflow     = head_rec.overflow;
  assign tok_o.last_of_byte = head_rec.last_of_byte;

endmodule

`default_nettype wire

// File: src/jts_scan_core.sv
// Scanner core: input byte register, scan state, nesting stack and record builder.
// Depends on jts_pkg and jts_byte_if.
`default_nettype none

module jts_scan_core import jts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jts_byte_if.sink  char_i,
  input  wire logic room_i,
  output rec_pair_t push_o
);

  localparam logic [TOK_CNT_W-1:0] TOK_FULL   = TOK_CNT_W'(MAX_TOKENS);
  localparam logic [DEPTH_W-1:0]   DEPTH_FULL = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0]   DEPTH_ONE  = DEPTH_W'(1);

  // Input register
  logic              in_vld_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_start_q;
  logic              fire;

  // Scan state
  scan_mode_e           mode_q, mode_d, mode_e;
  logic [POS_BITS-1:0]  pos_q, pos_d, pos_e;
  logic [TOK_CNT_W-1:0] tok_q, tok_d, tok_e;
  logic [DEPTH_W-1:0]   depth_q, depth_d, depth_e;
  logic                 err_q, err_d, err_e;
  logic                 done_q, done_d, done_e;
  logic [TOK_NUM_W-1:0] pend_idx_q, pend_idx_d;
  logic [POSX_W-1:0]    pend_start_q, pend_start_d;
  logic [POS_BITS-1:0]  pend_end_q, pend_end_d;

  // Nesting stack
  nest_entry_t          stk_q [MAX_DEPTH];
  logic                 stk_we;
  logic [STK_IDX_W-1:0] stk_wa;
  nest_entry_t          stk_wd;
  logic [STK_IDX_W-1:0] top_idx;
  nest_entry_t          top;

  // Working signals
  logic [CHAR_W-1:0]    c;
  logic [POSX_W-1:0]    pos_x;
  logic [POSX_W-1:0]    pos_nx;
  logic                 run_idle;
  logic                 do_alloc;
  logic                 do_push;
  logic                 do_close;
  logic                 push_arr;
  logic                 close_arr;
  logic [TOK_NUM_W-1:0] alloc_idx;
  logic                 rec_a_v;
  logic                 rec_b_v;
  tok_rec_t             rec_a;
  tok_rec_t             rec_b;

  // Take a byte when the register is free or drains this cycle
  assign fire         = in_vld_q && room_i;
  assign char_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (char_i.ready) begin
      in_vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q  <= char_i.char_byte;
      in_start_q <= char_i.doc_start;
    end
  end

  // State as seen by this byte, after an optional document restart
  assign c       = in_char_q;
  assign pos_e   = in_start_q ? '0 : pos_q;
  assign tok_e   = in_start_q ? '0 : tok_q;
  assign depth_e = in_start_q ? '0 : depth_q;
  assign mode_e  = in_start_q ? MODE_IDLE : mode_q;
  assign err_e   = in_start_q ? 1'b0 : err_q;
  assign done_e  = in_start_q ? 1'b0 : done_q;

  assign pos_x     = {1'b0, pos_e};
  assign pos_nx    = pos_x + 1'b1;
  assign top_idx   = STK_IDX_W'(depth_e - 1'b1);
  assign top       = stk_q[top_idx];
  assign alloc_idx = TOK_NUM_W'(tok_e);

  // Next scan state, stack update and records for one byte
  always_comb begin
    mode_d       = mode_q;
    pos_d        = pos_q;
    tok_d        = tok_q;
    depth_d      = depth_q;
    err_d        = err_q;
    done_d       = done_q;
    pend_idx_d   = pend_idx_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    stk_we       = 1'b0;
    stk_wa       = STK_IDX_W'(depth_e);
    stk_wd       = '0;
    run_idle     = 1'b0;
    do_alloc     = 1'b0;
    do_push      = 1'b0;
    do_close     = 1'b0;
    push_arr     = (c == CH_LBRACK);
    close_arr    = (c == CH_RBRACK);
    rec_a_v      = 1'b0;
    rec_b_v      = 1'b0;
    rec_a        = '0;
    rec_b        = '0;
    push_o       = '0;

    if (fire) begin
      pos_d   = pos_e + 1'b1;
      tok_d   = tok_e;
      depth_d = depth_e;
      mode_d  = mode_e;
      err_d   = err_e;
      done_d  = done_e;

      // Finish the token in progress
      unique case (mode_e)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            pend_end_d = pos_e;
            mode_d     = MODE_STR_DONE;
          end
        end
        MODE_PRIM: begin
          if ((c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACK)) begin
            rec_a_v            = 1'b1;
            rec_a.tok_number   = pend_idx_q;
            rec_a.tok_kind     = KIND_PRIM;
            rec_a.start_pos    = OUT_POS_W'(pend_start_q);
            rec_a.end_pos      = OUT_POS_W'(pos_e);
            rec_a.member_count = '0;
            mode_d             = MODE_IDLE;
            run_idle           = 1'b1;
          end
        end
        MODE_STR_DONE: begin
          rec_a_v            = 1'b1;
          rec_a.tok_number   = pend_idx_q;
          rec_a.tok_kind     = KIND_STRING;
          rec_a.start_pos    = OUT_POS_W'(pend_start_q);
          rec_a.end_pos      = OUT_POS_W'(pend_end_q);
          rec_a.member_count = SIZE_W'(c == CH_COLON);
          mode_d             = MODE_IDLE;
          run_idle           = 1'b1;
        end
        MODE_IDLE: begin
          run_idle = 1'b1;
        end
      endcase

      // Scan the byte between tokens
      if (run_idle) begin
        if (depth_e == '0) begin
          if (!done_e && ((c == CH_LBRACE) || (c == CH_LBRACK))) begin
            do_push = 1'b1;
          end
        end else begin
          priority if (c == CH_QUOTE) begin
            do_alloc     = 1'b1;
            pend_idx_d   = alloc_idx;
            pend_start_d = pos_nx;
            mode_d       = MODE_STR;
          end else if ((c == CH_LBRACE) || (c == CH_LBRACK)) begin
            do_push = 1'b1;
          end else if ((c == CH_RBRACE) || (c == CH_RBRACK)) begin
            do_close = (top.is_array == close_arr);
          end else if (c == CH_COMMA) begin
            stk_we = 1'b1;
            stk_wa = top_idx;
            stk_wd = top;
            if (top.commas < COMMA_SAT) begin
              stk_wd.commas = top.commas + 1'b1;
            end
          end else if (is_prim_start(c)) begin
            do_alloc     = 1'b1;
            pend_idx_d   = alloc_idx;
            pend_start_d = pos_x;
            mode_d       = MODE_PRIM;
          end else begin
            // ignore other bytes between tokens
          end
        end
      end

      // Open a container unless the stack is full
      if (do_push) begin
        if (depth_e >= DEPTH_FULL) begin
          err_d = 1'b1;
        end else begin
          do_alloc        = 1'b1;
          stk_we          = 1'b1;
          stk_wa          = STK_IDX_W'(depth_e);
          stk_wd.is_array = push_arr;
          stk_wd.index    = alloc_idx;
          stk_wd.start    = pos_e;
          stk_wd.commas   = '0;
          depth_d         = depth_e + 1'b1;
        end
      end

      // Close the top container
      if (do_close) begin
        rec_b_v            = 1'b1;
        rec_b.tok_number   = top.index;
        rec_b.tok_kind     = close_arr ? KIND_ARRAY : KIND_OBJECT;
        rec_b.start_pos    = OUT_POS_W'(top.start);
        rec_b.end_pos      = OUT_POS_W'(pos_nx);
        rec_b.member_count = top.commas + 1'b1;
        depth_d            = depth_e - 1'b1;
        if (depth_e == DEPTH_ONE) begin
          done_d = 1'b1;
        end
      end

      // Count the new token, saturating at the table size
      if (do_alloc) begin
        if (tok_e < TOK_FULL) begin
          tok_d = tok_e + 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end

      // Pack the records in order
      rec_a.overflow = err_d;
      rec_b.overflow = err_d;
      if (rec_a_v && rec_b_v) begin
        push_o.v0 = 1'b1;
        push_o.v1 = 1'b1;
        push_o.r0 = rec_a;
        push_o.r1 = rec_b;
        push_o.r1.last_of_byte = 1'b1;
      end else if (rec_a_v) begin
        push_o.v0 = 1'b1;
        push_o.r0 = rec_a;
        push_o.r0.last_of_byte = 1'b1;
      end else if (rec_b_v) begin
        push_o.v0 = 1'b1;
        push_o.r0 = rec_b;
        push_o.r0.last_of_byte = 1'b1;
      end
    end
  end

  // Scan mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Counters, flags and pending token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      tok_q        <= '0;
      depth_q      <= '0;
      err_q        <= 1'b0;
      done_q       <= 1'b0;
      pend_idx_q   <= '0;
      pend_start_q <= '0;
      pend_end_q   <= '0;
    end else begin
      pos_q        <= pos_d;
      tok_q        <= tok_d;
      depth_q      <= depth_d;
      err_q        <= err_d;
      done_q       <= done_d;
      pend_idx_q   <= pend_idx_d;
      pend_start_q <= pend_start_d;
      pend_end_q   <= pend_end_d;
    end
  end

  // Nesting stack; an entry is always written before it is read
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q[stk_wa] <= stk_wd;
    end
  end

endmodule

`default_nettype wire

// File: src/jts_checker.sv
// Port-level checks for the JSON token scanner, bound to the top level.
// Depends on jts_pkg and json_token_scanner_macros.svh.
`default_nettype none
`include "json_token_scanner_macros.svh"

module jts_checker import jts_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [TOK_NUM_W-1:0] out_number_i,
  input wire logic [KIND_W-1:0]    out_kind_i,
  input wire logic [OUT_POS_W-1:0] out_end_i,
  input wire logic                 out_last_i
);

  // Hold a stalled record
  `JTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `JTS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i,
    $stable(out_number_i) && $stable(out_end_i))

  // The second record of a byte follows right behind the first
  `JTS_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni,
    out_valid_i && out_ready_i && !out_last_i, out_valid_i)

  // Only a finished string or primitive can precede a container close
  `JTS_ASSERT_IMPLIES(a_first_kind, clk_i, rst_ni, out_valid_i && !out_last_i,
    (out_kind_i == KIND_STRING) || (out_kind_i == KIND_PRIM))

endmodule

bind json_token_scanner jts_checker u_jts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (tok_o.valid),
  .out_ready_i  (tok_o.ready),
  .out_number_i (tok_o.tok_number),
  .out_kind_i   (tok_o.tok_kind),
  .out_end_i    (tok_o.end_pos),
  .out_last_i   (tok_o.last_of_byte)
);

`default_nettype wire
